@@ hdl/ipv4_receive_header_check_assert.svh @@
// Assertion macros used by the header check RTL.
`ifndef IPV4_RECEIVE_HEADER_CHECK_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_CHECK_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IPV4RHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IPV4RHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ipv4rhc_pkg.sv @@
package ipv4rhc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IFACE_PRESENT = 2'd0,
    CFG_IFACE_UNICAST = 2'd1,
    CFG_IFACE_NETMASK = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  // Verdict codes
  typedef enum logic [3:0] {
    DROP_NONE      = 4'd0,
    DROP_NO_IFACE  = 4'd1,
    DROP_SHORT     = 4'd2,
    DROP_VERSION   = 4'd3,
    DROP_HLEN      = 4'd4,
    DROP_TOTAL     = 4'd5,
    DROP_CHECKSUM  = 4'd6,
    DROP_FRAGMENT  = 4'd7,
    DROP_ADDRESS   = 4'd8
  } drop_reason_e;

  localparam logic [7:0]  VL_HLEN_MASK     = 8'h0f;
  localparam logic [15:0] MF_FLAG          = 16'h2000;
  localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
  localparam logic [31:0] ALL_ONES_ADDR    = 32'hffffffff;
  localparam logic [15:0] MIN_FRAME_BYTES  = 16'd20;
  localparam logic [3:0]  IP_VERSION       = 4'd4;
  localparam logic [15:0] BYTE_COUNT_MAX   = 16'hffff;
  localparam logic [15:0] CHECKSUM_GOOD    = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rx_beat_t;

  typedef struct packed {
    logic        accept;
    logic [3:0]  drop_reason;
    logic [7:0]  protocol_number;
    logic [5:0]  header_bytes;
    logic [15:0] payload_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } result_t;

endpackage

@@ hdl/ipv4rhc_stream_if.sv @@
interface ipv4rhc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/ipv4_receive_header_check.sv @@
// IPv4 receive header check.
// rx_i (sink, payload ipv4rhc_pkg::rx_beat_t) takes one frame byte per beat in wire
// order, last_byte set on the final beat of the frame. res_o (source, payload
// ipv4rhc_pkg::result_t) gives one verdict beat per frame: accept, drop reason,
// protocol, header length, payload length and both addresses.
// The cfg_* port writes interface present / unicast / netmask; write only while
// no frame is in flight. Register index 3 is ignored.
// Throughput: one byte per cycle, but a last byte waits while the receiver stalls.
// A byte is taken into the input register, where the field capture, checksum
// fold and verdict are formed, and the verdict of a last byte lands in the
// result register, which drives the result beat.
// When the receiver stalls, the verdict holds in the result register; bytes
// that are not the last keep flowing, and a last byte waits in the input
// register until the result register frees up, which then holds off rx_i.
// Reset clears the frame state, the configuration and both valid flags.
module ipv4_receive_header_check (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [ipv4rhc_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [ipv4rhc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  ipv4rhc_stream_if.sink                         rx_i,
  ipv4rhc_stream_if.source                       res_o
);

  // Byte offsets within the header
  localparam logic [15:0] OffTotalHi = 16'd2;
  localparam logic [15:0] OffTotalLo = 16'd3;
  localparam logic [15:0] OffFragHi  = 16'd6;
  localparam logic [15:0] OffFragLo  = 16'd7;
  localparam logic [15:0] OffProto   = 16'd9;
  localparam logic [15:0] OffSrc0    = 16'd12;
  localparam logic [15:0] OffSrc1    = 16'd13;
  localparam logic [15:0] OffSrc2    = 16'd14;
  localparam logic [15:0] OffSrc3    = 16'd15;
  localparam logic [15:0] OffDst0    = 16'd16;
  localparam logic [15:0] OffDst1    = 16'd17;
  localparam logic [15:0] OffDst2    = 16'd18;
  localparam logic [15:0] OffDst3    = 16'd19;

  // Configuration
  logic        iface_present_q;
  logic [31:0] iface_unicast_q;
  logic [31:0] iface_netmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iface_present_q <= 1'b0;
      iface_unicast_q <= '0;
      iface_netmask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ipv4rhc_pkg::cfg_reg_e'(cfg_index_i))
        ipv4rhc_pkg::CFG_IFACE_PRESENT: iface_present_q <= cfg_data_i[0];
        ipv4rhc_pkg::CFG_IFACE_UNICAST: iface_unicast_q <= cfg_data_i;
        ipv4rhc_pkg::CFG_IFACE_NETMASK: iface_netmask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic                  s1_valid_q;
  ipv4rhc_pkg::rx_beat_t s1_q;
  logic                  out_valid_q;
  ipv4rhc_pkg::result_t  out_q;
  logic                  out_free;
  logic                  s1_adv;
  logic                  s1_fire;
  logic                  s1_verdict;

  // A last byte needs the result register; any other byte moves on freely.
  assign out_free   = !out_valid_q || res_o.ready;
  assign s1_adv     = !s1_q.last_byte || out_free;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign s1_verdict = s1_fire && s1_q.last_byte;
  assign rx_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_q <= rx_i.payload;
    end
  end

  // Per-frame state
  logic [15:0] cnt_q,   cnt_d;
  logic [7:0]  vl_q,    vl_d;
  logic [15:0] total_q, total_d;
  logic [15:0] frag_q,  frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q,   src_d;
  logic [31:0] dst_q,   dst_d;
  logic [15:0] chk_q,   chk_d;
  logic [7:0]  hb_q,    hb_d;

  logic [7:0]  b;
  logic [5:0]  hlen;
  logic [7:0]  vl_masked;
  logic [16:0] chk_sum;

  assign b = s1_q.data_byte;

  always_comb begin
    vl_d      = (cnt_q == '0) ? b : vl_q;
    vl_masked = vl_d & ipv4rhc_pkg::VL_HLEN_MASK;
    hlen      = {vl_masked[3:0], 2'b00};

    total_d = total_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    unique case (cnt_q)
      OffTotalHi: total_d[15:8] = b;
      OffTotalLo: total_d[7:0]  = b;
      OffFragHi:  frag_d[15:8]  = b;
      OffFragLo:  frag_d[7:0]   = b;
      OffProto:   proto_d       = b;
      OffSrc0:    src_d[31:24]  = b;
      OffSrc1:    src_d[23:16]  = b;
      OffSrc2:    src_d[15:8]   = b;
      OffSrc3:    src_d[7:0]    = b;
      OffDst0:    dst_d[31:24]  = b;
      OffDst1:    dst_d[23:16]  = b;
      OffDst2:    dst_d[15:8]   = b;
      OffDst3:    dst_d[7:0]    = b;
      default: ;
    endcase

    // Ones-complement sum with end-around carry over the header words
    chk_sum = {1'b0, chk_q} + {1'b0, hb_q, b};
    hb_d    = hb_q;
    chk_d   = chk_q;
    if (cnt_q < {10'd0, hlen}) begin
      if (!cnt_q[0]) begin
        hb_d = b;
      end else begin
        chk_d = chk_sum[15:0] + {15'd0, chk_sum[16]};
      end
    end

    // Saturate the byte count
    cnt_d = (cnt_q == ipv4rhc_pkg::BYTE_COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      vl_q    <= '0;
      total_q <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      chk_q   <= '0;
      hb_q    <= '0;
    end else if (s1_verdict) begin
      // Clear for the next frame
      cnt_q   <= '0;
      vl_q    <= '0;
      total_q <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      chk_q   <= '0;
      hb_q    <= '0;
    end else if (s1_fire) begin
      cnt_q   <= cnt_d;
      vl_q    <= vl_d;
      total_q <= total_d;
      frag_q  <= frag_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      chk_q   <= chk_d;
      hb_q    <= hb_d;
    end
  end

  // Verdict: first failing check wins
  ipv4rhc_pkg::drop_reason_e reason;
  logic [31:0]               bcast;
  logic [15:0]               payload_len;
  ipv4rhc_pkg::result_t      res_d;

  assign bcast = (iface_unicast_q & iface_netmask_q) | ~iface_netmask_q;

  always_comb begin
    priority if (!iface_present_q) begin
      reason = ipv4rhc_pkg::DROP_NO_IFACE;
    end else if (cnt_d < ipv4rhc_pkg::MIN_FRAME_BYTES) begin
      reason = ipv4rhc_pkg::DROP_SHORT;
    end else if (vl_d[7:4] != ipv4rhc_pkg::IP_VERSION) begin
      reason = ipv4rhc_pkg::DROP_VERSION;
    end else if ({10'd0, hlen} > cnt_d) begin
      reason = ipv4rhc_pkg::DROP_HLEN;
    end else if (total_d > cnt_d) begin
      reason = ipv4rhc_pkg::DROP_TOTAL;
    end else if (chk_d != ipv4rhc_pkg::CHECKSUM_GOOD) begin
      reason = ipv4rhc_pkg::DROP_CHECKSUM;
    end else if ((frag_d & ipv4rhc_pkg::MF_FLAG) != '0
                 || (frag_d & ipv4rhc_pkg::FRAG_OFFSET_MASK) != '0) begin
      reason = ipv4rhc_pkg::DROP_FRAGMENT;
    end else if (dst_d != iface_unicast_q && dst_d != bcast
                 && dst_d != ipv4rhc_pkg::ALL_ONES_ADDR) begin
      reason = ipv4rhc_pkg::DROP_ADDRESS;
    end else begin
      reason = ipv4rhc_pkg::DROP_NONE;
    end

    // Payload length is zero on a dropped frame and floors at zero when the total is below the header
    if (reason == ipv4rhc_pkg::DROP_NONE && total_d >= {10'd0, hlen}) begin
      payload_len = total_d - {10'd0, hlen};
    end else begin
      payload_len = '0;
    end

    res_d.accept          = (reason == ipv4rhc_pkg::DROP_NONE);
    res_d.drop_reason     = reason;
    res_d.protocol_number = proto_d;
    res_d.header_bytes    = hlen;
    res_d.payload_length  = payload_len;
    res_d.source_address  = src_d;
    res_d.dest_address    = dst_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_verdict) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_verdict) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

`include "ipv4_receive_header_check_assert.svh"

  `IPV4RHC_ASSERT_NOW(a_accept_matches_reason, out_valid_q, out_q.accept == (out_q.drop_reason == ipv4rhc_pkg::DROP_NONE), "accept flag disagrees with drop reason")
  `IPV4RHC_ASSERT_NOW(a_payload_only_on_accept, out_valid_q && !out_q.accept, out_q.payload_length == '0, "payload length reported on a dropped frame")
  `IPV4RHC_ASSERT_NEXT(a_frame_state_cleared, s1_verdict, cnt_q == '0 && chk_q == '0 && dst_q == '0, "frame state not cleared after verdict")
  `IPV4RHC_ASSERT_NEXT(a_count_advances, s1_fire && !s1_q.last_byte, cnt_q != '0, "byte count did not advance")
  `IPV4RHC_ASSERT_NOW(a_result_from_last_byte, $rose(out_valid_q), $past(s1_verdict), "result beat without a last byte")

endmodule
